@@ hdl/hbtr_pkg.sv @@
// Shared constants, types and register indexes for the binary descriptor
// best-two ratio matcher. No dependencies.
package hbtr_pkg;

    localparam int DESC_BITS  = 256;
    localparam int INDEX_BITS = 12;

    localparam int WORD_W    = 64;
    localparam int DESC_W    = 4 * WORD_W;
    localparam int IDX_W     = 12;
    localparam int LVL_W     = 4;
    localparam int DIST_W    = 9;
    localparam int CFG_W     = 9;
    localparam int CFG_IDX_W = 4;
    localparam int PROD_W    = 2 * CFG_W;

    localparam logic [DESC_W-1:0] DESC_MASK =
        DESC_W'(((DESC_W + 1)'(1) << DESC_BITS) - (DESC_W + 1)'(1));
    localparam logic [IDX_W-1:0] IDX_MASK =
        IDX_W'((17'(1) << INDEX_BITS) - 17'(1));

    localparam logic [CFG_IDX_W-1:0] REG_RATIO_Q8     = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_MAX_DISTANCE = CFG_IDX_W'(1);

    localparam logic [CFG_W-1:0]  RATIO_RESET   = CFG_W'(154);
    localparam logic [CFG_W-1:0]  MAXD_RESET    = CFG_W'(100);
    localparam logic [DIST_W-1:0] NO_MATCH_DIST = DIST_W'(256);

    typedef struct packed {
        logic [DIST_W-1:0] ham_dist;
        logic [IDX_W-1:0]  idx;
        logic [LVL_W-1:0]  lvl;
        logic              occupied;
        logic              last;
    } cand_t;

    typedef struct packed {
        logic [DIST_W-1:0] best_dist;
        logic [DIST_W-1:0] second_dist;
        logic              best_valid;
        logic              second_valid;
        logic              same_lvl;
        logic [IDX_W-1:0]  best_idx;
    } snap_t;

endpackage

@@ hdl/hbtr_if.sv @@
// Request channel interfaces: candidate requests in, match results out.
// Depends on hbtr_pkg.
interface hbtr_cand_if import hbtr_pkg::*; ();
    logic               valid;
    logic               ready;
    logic [WORD_W-1:0]  query_word0;
    logic [WORD_W-1:0]  query_word1;
    logic [WORD_W-1:0]  query_word2;
    logic [WORD_W-1:0]  query_word3;
    logic [WORD_W-1:0]  cand_word0;
    logic [WORD_W-1:0]  cand_word1;
    logic [WORD_W-1:0]  cand_word2;
    logic [WORD_W-1:0]  cand_word3;
    logic [IDX_W-1:0]   cand_index;
    logic [LVL_W-1:0]   cand_level;
    logic               cand_occupied;
    logic               group_last;

    modport source (
        output valid, query_word0, query_word1, query_word2, query_word3,
               cand_word0, cand_word1, cand_word2, cand_word3,
               cand_index, cand_level, cand_occupied, group_last,
        input  ready
    );
    modport sink (
        input  valid, query_word0, query_word1, query_word2, query_word3,
               cand_word0, cand_word1, cand_word2, cand_word3,
               cand_index, cand_level, cand_occupied, group_last,
        output ready
    );
endinterface

interface hbtr_result_if import hbtr_pkg::*; ();
    logic              valid;
    logic              ready;
    logic              match_found;
    logic [IDX_W-1:0]  match_index;
    logic [DIST_W-1:0] match_distance;

    modport source (
        output valid, match_found, match_index, match_distance,
        input  ready
    );
    modport sink (
        input  valid, match_found, match_index, match_distance,
        output ready
    );
endinterface

@@ hdl/hamming_best_two_ratio_match_core.sv @@
// Binary descriptor matcher: Hamming nearest neighbor with a best-two ratio
// test. Takes one candidate request per clock while results are taken, with
// no gaps at group boundaries; the tracker update (popcount result, two
// compares) is the loop that sets that rate. The user must write ratio and
// distance limit through the cfg port only while no group is in flight; the
// block itself does not enforce this. Depends on hbtr_pkg, hbtr_if,
// hbtr_dist_stage, hbtr_tracker, hbtr_decide.
module hamming_best_two_ratio_match_core import hbtr_pkg::*; (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_data,
    hbtr_cand_if.sink            cand,
    hbtr_result_if.source        result
);

    cand_t dist_item;
    logic  dist_valid;
    logic  dist_ready;
    snap_t snap;
    logic  snap_valid;
    logic  snap_ready;

    hbtr_dist_stage u_dist (
        .clk        (clk),
        .rst_n      (rst_n),
        .cand       (cand),
        .dist_item  (dist_item),
        .dist_valid (dist_valid),
        .dist_ready (dist_ready)
    );

    hbtr_tracker u_tracker (
        .clk        (clk),
        .rst_n      (rst_n),
        .item       (dist_item),
        .item_valid (dist_valid),
        .item_ready (dist_ready),
        .snap       (snap),
        .snap_valid (snap_valid),
        .snap_ready (snap_ready)
    );

    hbtr_decide u_decide (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .snap       (snap),
        .snap_valid (snap_valid),
        .snap_ready (snap_ready),
        .result     (result)
    );

endmodule

@@ hdl/hbtr_dist_stage.sv @@
// Input register and Hamming distance stage: registers the masked XOR of
// query and candidate, then a popcount tree into the distance register.
// Depends on hbtr_pkg and hbtr_if.
module hbtr_dist_stage import hbtr_pkg::*; (
    input  logic        clk,
    input  logic        rst_n,
    hbtr_cand_if.sink   cand,
    output cand_t       dist_item,
    output logic        dist_valid,
    input  logic        dist_ready
);

    logic [DESC_W-1:0] diff_reg;
    logic [IDX_W-1:0]  idx_reg;
    logic [LVL_W-1:0]  lvl_reg;
    logic              occ_reg;
    logic              last_reg;
    logic              v0_reg;

    cand_t             item_reg;
    logic              v1_reg;

    logic              s0_ready;
    logic              s1_ready;

    logic [3:0]        cnt8   [32];
    logic [4:0]        cnt16  [16];
    logic [5:0]        cnt32  [8];
    logic [6:0]        cnt64  [4];
    logic [7:0]        cnt128 [2];
    logic [DIST_W-1:0] dist_next;

    assign s1_ready   = !v1_reg || dist_ready;
    assign s0_ready   = !v0_reg || s1_ready;
    assign cand.ready = s0_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v0_reg <= 1'b0;
            v1_reg <= 1'b0;
        end
        else
        begin
            if (s0_ready)
            begin
                v0_reg <= cand.valid;
            end
            if (s1_ready)
            begin
                v1_reg <= v0_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s0_ready && cand.valid)
        begin
            diff_reg <= ({cand.query_word3, cand.query_word2,
                          cand.query_word1, cand.query_word0} ^
                         {cand.cand_word3, cand.cand_word2,
                          cand.cand_word1, cand.cand_word0}) & DESC_MASK;
            idx_reg  <= cand.cand_index & IDX_MASK;
            lvl_reg  <= cand.cand_level;
            occ_reg  <= cand.cand_occupied;
            last_reg <= cand.group_last;
        end
        if (s1_ready && v0_reg)
        begin
            item_reg.ham_dist <= dist_next;
            item_reg.idx      <= idx_reg;
            item_reg.lvl      <= lvl_reg;
            item_reg.occupied <= occ_reg;
            item_reg.last     <= last_reg;
        end
    end

    // popcount: per-byte counts, then a pairwise adder tree
    always_comb
    begin
        for (int i = 0; i < 32; i++)
        begin
            cnt8[i] = 4'd0;
            for (int j = 0; j < 8; j++)
            begin
                cnt8[i] = cnt8[i] + 4'(diff_reg[8*i+j]);
            end
        end
        for (int i = 0; i < 16; i++)
        begin
            cnt16[i] = 5'(cnt8[2*i]) + 5'(cnt8[2*i+1]);
        end
        for (int i = 0; i < 8; i++)
        begin
            cnt32[i] = 6'(cnt16[2*i]) + 6'(cnt16[2*i+1]);
        end
        for (int i = 0; i < 4; i++)
        begin
            cnt64[i] = 7'(cnt32[2*i]) + 7'(cnt32[2*i+1]);
        end
        for (int i = 0; i < 2; i++)
        begin
            cnt128[i] = 8'(cnt64[2*i]) + 8'(cnt64[2*i+1]);
        end
        dist_next = DIST_W'(cnt128[0]) + DIST_W'(cnt128[1]);
    end

    assign dist_item  = item_reg;
    assign dist_valid = v1_reg;

endmodule

@@ hdl/hbtr_tracker.sv @@
// Best and second-best tracker: one update per candidate, and on the last
// candidate of a group a snapshot for the ratio test. Depends on hbtr_pkg.
module hbtr_tracker import hbtr_pkg::*; (
    input  logic   clk,
    input  logic   rst_n,
    input  cand_t  item,
    input  logic   item_valid,
    output logic   item_ready,
    output snap_t  snap,
    output logic   snap_valid,
    input  logic   snap_ready
);

    logic [DIST_W-1:0] best_dist_reg,   best_dist_next;
    logic [DIST_W-1:0] second_dist_reg, second_dist_next;
    logic              best_valid_reg,  best_valid_next;
    logic              second_valid_reg, second_valid_next;
    logic [LVL_W-1:0]  best_lvl_reg,    best_lvl_next;
    logic [LVL_W-1:0]  second_lvl_reg,  second_lvl_next;
    logic [IDX_W-1:0]  best_idx_reg,    best_idx_next;

    snap_t             snap_reg;
    logic              snap_valid_reg;
    logic              take;

    assign item_ready = !item.last || !snap_valid_reg || snap_ready;
    assign take       = item_valid && item_ready;

    always_comb
    begin
        best_dist_next    = best_dist_reg;
        second_dist_next  = second_dist_reg;
        best_valid_next   = best_valid_reg;
        second_valid_next = second_valid_reg;
        best_lvl_next     = best_lvl_reg;
        second_lvl_next   = second_lvl_reg;
        best_idx_next     = best_idx_reg;
        if (!item.occupied)
        begin
            if (!best_valid_reg || item.ham_dist < best_dist_reg)
            begin
                second_dist_next  = best_dist_reg;
                second_valid_next = best_valid_reg;
                second_lvl_next   = best_lvl_reg;
                best_dist_next    = item.ham_dist;
                best_valid_next   = 1'b1;
                best_lvl_next     = item.lvl;
                best_idx_next     = item.idx;
            end
            else if (!second_valid_reg || item.ham_dist < second_dist_reg)
            begin
                second_dist_next  = item.ham_dist;
                second_valid_next = 1'b1;
                second_lvl_next   = item.lvl;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            best_valid_reg   <= 1'b0;
            second_valid_reg <= 1'b0;
            snap_valid_reg   <= 1'b0;
        end
        else
        begin
            if (take)
            begin
                // end of group clears the trackers
                best_valid_reg   <= best_valid_next && !item.last;
                second_valid_reg <= second_valid_next && !item.last;
            end
            if (take && item.last)
            begin
                snap_valid_reg <= 1'b1;
            end
            else if (snap_ready)
            begin
                snap_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            best_dist_reg   <= best_dist_next;
            second_dist_reg <= second_dist_next;
            best_lvl_reg    <= best_lvl_next;
            second_lvl_reg  <= second_lvl_next;
            best_idx_reg    <= best_idx_next;
        end
        if (take && item.last)
        begin
            snap_reg.best_dist    <= best_dist_next;
            snap_reg.second_dist  <= second_dist_next;
            snap_reg.best_valid   <= best_valid_next;
            snap_reg.second_valid <= second_valid_next;
            snap_reg.same_lvl     <= (best_lvl_next == second_lvl_next);
            snap_reg.best_idx     <= best_idx_next;
        end
    end

    assign snap       = snap_reg;
    assign snap_valid = snap_valid_reg;

endmodule

@@ hdl/hbtr_decide.sv @@
// Ratio test and distance threshold on a group snapshot, configuration
// registers and the result register. Depends on hbtr_pkg and hbtr_if.
module hbtr_decide import hbtr_pkg::*; (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_data,
    input  snap_t                snap,
    input  logic                 snap_valid,
    output logic                 snap_ready,
    hbtr_result_if.source        result
);

    logic [CFG_W-1:0]  ratio_reg;
    logic [CFG_W-1:0]  maxd_reg;

    logic              valid_reg;
    logic              found_reg;
    logic [IDX_W-1:0]  index_reg;
    logic [DIST_W-1:0] dist_reg;

    logic [PROD_W-1:0] ratio_prod;
    logic [PROD_W-1:0] best_scaled;
    logic              reject;
    logic              found_next;

    assign snap_ready = !valid_reg || result.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ratio_reg <= RATIO_RESET;
            maxd_reg  <= MAXD_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_RATIO_Q8:     ratio_reg <= cfg_data;
                REG_MAX_DISTANCE: maxd_reg  <= cfg_data;
                default:          ;
            endcase
        end
    end

    assign ratio_prod  = PROD_W'(ratio_reg) * PROD_W'(snap.second_dist);
    assign best_scaled = PROD_W'({snap.best_dist, 8'd0});
    assign reject      = snap.second_valid && snap.same_lvl && (best_scaled > ratio_prod);
    assign found_next  = snap.best_valid && (snap.best_dist <= maxd_reg) && !reject;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (snap_ready)
        begin
            valid_reg <= snap_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (snap_ready && snap_valid)
        begin
            found_reg <= found_next;
            index_reg <= found_next ? snap.best_idx : '0;
            dist_reg  <= found_next ? snap.best_dist : NO_MATCH_DIST;
        end
    end

    assign result.valid          = valid_reg;
    assign result.match_found    = found_reg;
    assign result.match_index    = index_reg;
    assign result.match_distance = dist_reg;

endmodule

@@ hdl/hbtr_checker.sv @@
// Port-level assertions for the matcher core and their bind.
// Depends on hbtr_pkg and hamming_best_two_ratio_match_core.
module hbtr_checker import hbtr_pkg::*; (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cand_valid,
    input  logic              cand_ready,
    input  logic              group_last,
    input  logic              res_valid,
    input  logic              res_ready,
    input  logic              match_found,
    input  logic [IDX_W-1:0]  match_index,
    input  logic [DIST_W-1:0] match_distance
);

    // groups closed on the input side but not yet delivered
    logic [2:0] pending_reg;
    logic [2:0] pending_next;
    logic       last_take;
    logic       res_take;

    assign last_take    = cand_valid && cand_ready && group_last;
    assign res_take     = res_valid && res_ready;
    assign pending_next = pending_reg + 3'(last_take) - 3'(res_take);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pending_reg <= 3'd0;
        end
        else
        begin
            pending_reg <= pending_next;
        end
    end

    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |=> res_valid && $stable(match_found)
            && $stable(match_index) && $stable(match_distance))
        else $error("result changed while stalled");

    a_no_match_fields: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !match_found |-> match_index == '0
            && match_distance == NO_MATCH_DIST)
        else $error("rejected result carries index or distance");

    a_result_has_group: assert property (@(posedge clk) disable iff (!rst_n)
        res_take |-> pending_reg != 3'd0)
        else $error("result without a closed group");

    a_pending_bound: assert property (@(posedge clk) disable iff (!rst_n)
        pending_reg <= 3'd4)
        else $error("more closed groups in flight than pipeline slots");

endmodule

bind hamming_best_two_ratio_match_core hbtr_checker u_hbtr_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .cand_valid     (cand.valid),
    .cand_ready     (cand.ready),
    .group_last     (cand.group_last),
    .res_valid      (result.valid),
    .res_ready      (result.ready),
    .match_found    (result.match_found),
    .match_index    (result.match_index),
    .match_distance (result.match_distance)
);
